@@ rtl/mcp_pkg.sv @@
// Package for the mode command token parser: word types, register codes, keyword table.
`timescale 1ns / 1ps
`default_nettype none
package mcp_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} cmd_word_t;

	typedef struct packed {
		logic       found;
		logic [7:0] mode_code;
	} res_word_t;

	typedef struct packed {
		logic [7:0] straight_code;
		logic [7:0] autocross_code;
		logic [7:0] skidpad_code;
		logic [7:0] endurance_code;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_STRAIGHT  = 2'd0,
		REG_AUTOCROSS = 2'd1,
		REG_SKIDPAD   = 2'd2,
		REG_ENDURANCE = 2'd3
	} reg_idx_t;

	localparam int ADDR_W   = 4;
	localparam int KW_COUNT = 5;
	localparam int KW_MAX   = 9;
	localparam int POS_W    = $clog2(KW_MAX);

	localparam int KW_STRAIGHT  = 0;
	localparam int KW_AUTOCROSS = 1;
	localparam int KW_AVOIDANCE = 2;
	localparam int KW_SKIDPAD   = 3;
	localparam int KW_ENDURANCE = 4;

	// keywords padded to full width with trailing spaces, read from the left
	localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
		"straight ", "autocross", "avoidance", "skidpad  ", "endurance"
	};
	localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd8, 8'd9, 8'd9, 8'd7, 8'd9};

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// true when keyword k still matches lower-case byte lc at core position pos
	function automatic logic kw_hit(input int k, input logic [7:0] pos, input logic [7:0] lc);
		logic [POS_W-1:0] idx;
		logic [7:0]       ch;
		idx = pos[POS_W-1:0];
		ch  = KW_TEXT[k][8*(KW_MAX-1-int'(idx)) +: 8];
		return (pos < KW_LEN[k]) && (ch == lc);
	endfunction

endpackage
`default_nettype wire

@@ rtl/mcp_msg.sv @@
// Message state of the parser: per-byte update and end-of-message rule evaluation.
`timescale 1ns / 1ps
`default_nettype none
module mcp_msg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire mcp_pkg::cmd_word_t word,
	input  wire mcp_pkg::cfg_t      cfg,
	output mcp_pkg::res_word_t      res
);
	import mcp_pkg::*;

	logic                seen_q, all_dig_q, too_long_q;
	logic [7:0]          core_len_q, pend_q, first_q, bcount_q;
	logic [15:0]         dsum_q;
	logic [KW_COUNT-1:0] kw_alive_q;

	logic                seen_n, all_dig_n, too_long_n;
	logic [7:0]          core_len_n, pend_n, first_n, bcount_n;
	logic [15:0]         dsum_n;
	logic [KW_COUNT-1:0] kw_alive_n;

	always_comb begin
		logic       blank;
		logic [7:0] b;
		logic [7:0] lc;
		logic [7:0] pos;
		logic       ok;
		logic       rng_first, rng_dec;
		b          = word.byte_in;
		seen_n     = seen_q;
		all_dig_n  = all_dig_q;
		too_long_n = too_long_q;
		core_len_n = core_len_q;
		pend_n     = pend_q;
		first_n    = first_q;
		bcount_n   = bcount_q;
		dsum_n     = dsum_q;
		kw_alive_n = kw_alive_q;
		pos        = 8'd0;
		lc         = b;
		blank      = (b == CH_SPACE) || (b == CH_TAB);

		if (bcount_q == 8'hFF) begin
			too_long_n = 1'b1;
		end else begin
			bcount_n = bcount_q + 8'd1;
		end

		if (blank) begin
			if (seen_q && pend_q != 8'hFF) begin
				pend_n = pend_q + 8'd1;
			end
		end else begin
			if (pend_q != 8'd0) begin
				// blanks inside the core break every rule
				all_dig_n  = 1'b0;
				kw_alive_n = '0;
				core_len_n = core_len_q + pend_q;
				pend_n     = 8'd0;
			end
			seen_n = 1'b1;
			pos    = core_len_n;
			if (b >= CH_UP_A && b <= CH_UP_Z) begin
				lc = b + CASE_OFS;
			end
			for (int k = 0; k < KW_COUNT; k++) begin
				if (!kw_hit(k, pos, lc)) begin
					kw_alive_n[k] = 1'b0;
				end
			end
			if (b >= CH_ZERO && b <= CH_NINE) begin
				dsum_n = {dsum_q[12:0], 3'b000} + {dsum_q[14:0], 1'b0}
					+ {12'd0, b[3:0]};
			end else begin
				all_dig_n = 1'b0;
			end
			if (pos == 8'd0) begin
				first_n = b;
			end
			core_len_n = pos + 8'd1;
		end

		ok        = !too_long_n && seen_n && (core_len_n != 8'd0);
		rng_first = (first_n >= cfg.straight_code) && (first_n <= cfg.endurance_code);
		rng_dec   = (dsum_n >= {8'd0, cfg.straight_code})
			&& (dsum_n <= {8'd0, cfg.endurance_code});

		res = '0;
		if (ok) begin
			if (core_len_n == 8'd1 && rng_first) begin
				res.found     = 1'b1;
				res.mode_code = first_n;
			end else if (all_dig_n && rng_dec) begin
				res.found     = 1'b1;
				res.mode_code = dsum_n[7:0];
			end else if (kw_alive_n[KW_STRAIGHT] && core_len_n == KW_LEN[KW_STRAIGHT]) begin
				res.found     = 1'b1;
				res.mode_code = cfg.straight_code;
			end else if ((kw_alive_n[KW_AUTOCROSS] && core_len_n == KW_LEN[KW_AUTOCROSS])
				|| (kw_alive_n[KW_AVOIDANCE] && core_len_n == KW_LEN[KW_AVOIDANCE])) begin
				res.found     = 1'b1;
				res.mode_code = cfg.autocross_code;
			end else if (kw_alive_n[KW_SKIDPAD] && core_len_n == KW_LEN[KW_SKIDPAD]) begin
				res.found     = 1'b1;
				res.mode_code = cfg.skidpad_code;
			end else if (kw_alive_n[KW_ENDURANCE] && core_len_n == KW_LEN[KW_ENDURANCE]) begin
				res.found     = 1'b1;
				res.mode_code = cfg.endurance_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			all_dig_q  <= 1'b1;
			too_long_q <= 1'b0;
			core_len_q <= 8'd0;
			pend_q     <= 8'd0;
			first_q    <= 8'd0;
			bcount_q   <= 8'd0;
			dsum_q     <= 16'd0;
			kw_alive_q <= '1;
		end else if (step) begin
			if (word.last_byte) begin
				seen_q     <= 1'b0;
				all_dig_q  <= 1'b1;
				too_long_q <= 1'b0;
				core_len_q <= 8'd0;
				pend_q     <= 8'd0;
				first_q    <= 8'd0;
				bcount_q   <= 8'd0;
				dsum_q     <= 16'd0;
				kw_alive_q <= '1;
			end else begin
				seen_q     <= seen_n;
				all_dig_q  <= all_dig_n;
				too_long_q <= too_long_n;
				core_len_q <= core_len_n;
				pend_q     <= pend_n;
				first_q    <= first_n;
				bcount_q   <= bcount_n;
				dsum_q     <= dsum_n;
				kw_alive_q <= kw_alive_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/mode_command_token_parser.sv @@
// Top level of the mode command token parser: handshake, registers, result stage.
// Throughput: one byte word per cycle, set by the per-byte update in mcp_msg, while
//   no last byte is held by a stalled result. An accepted last byte enters the input
//   register, then its result word is captured in the result register and shown valid.
// A stalled result only holds back the stage when that stage holds a last byte.
// Reset (arst_n low, asynchronous): message state cleared, pipeline empty,
//   mode codes return to 1, 2, 3, 4.
`timescale 1ns / 1ps
`default_nettype none
module mode_command_token_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// byte words in
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire mcp_pkg::cmd_word_t         cmd_word,
	// result words out
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output mcp_pkg::res_word_t              res_word,
	// register port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mcp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import mcp_pkg::*;

	cfg_t      cfg_q;
	logic      v_s1;
	cmd_word_t word_s1;
	logic      res_valid_q;
	res_word_t res_word_q;
	res_word_t msg_res;
	logic      adv;
	logic      accept;
	logic      wr_en;
	reg_idx_t  reg_idx;

	// ---- register port ----
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.straight_code  <= 8'd1;
			cfg_q.autocross_code <= 8'd2;
			cfg_q.skidpad_code   <= 8'd3;
			cfg_q.endurance_code <= 8'd4;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STRAIGHT:  cfg_q.straight_code  <= pwdata[7:0];
				REG_AUTOCROSS: cfg_q.autocross_code <= pwdata[7:0];
				REG_SKIDPAD:   cfg_q.skidpad_code   <= pwdata[7:0];
				REG_ENDURANCE: cfg_q.endurance_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STRAIGHT:  prdata = {24'd0, cfg_q.straight_code};
			REG_AUTOCROSS: prdata = {24'd0, cfg_q.autocross_code};
			REG_SKIDPAD:   prdata = {24'd0, cfg_q.skidpad_code};
			REG_ENDURANCE: prdata = {24'd0, cfg_q.endurance_code};
			default:       prdata = 32'd0;
		endcase
	end

	// ---- input stage ----
	// A non-last byte always moves on; a last byte needs room in the result register.
	assign adv       = v_s1 && (!word_s1.last_byte || !res_valid_q || !res_stall);
	assign cmd_stall = v_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= cmd_word;
		end
	end

	// ---- message state and rule evaluation ----
	mcp_msg u_msg (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.word   (word_s1),
		.cfg    (cfg_q),
		.res    (msg_res)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && word_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last_byte) begin
			res_word_q <= msg_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// ---- checks ----
	// stall is only raised by a held last byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (v_s1 && word_s1.last_byte && res_valid_q && res_stall))
		else $error("input stalled without a blocked last byte");

	// no-match results carry a zero code
	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_word.found) |-> (res_word.mode_code == 8'd0))
		else $error("no-match result with non-zero mode code");

	// a new result only follows a last byte leaving the input stage
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(adv && word_s1.last_byte))
		else $error("result word appeared without a last byte");

	// a waiting result is not dropped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("stalled result word lost");

endmodule
`default_nettype wire
